>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

>>> hdl/spom_pkg.sv
`timescale 1ns / 1ps

package spom_pkg;

    localparam int DIM_W       = 4;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = DIM_W + 1;
    localparam int PROD_W      = 2 * DIM_W;
    localparam int MAX_DIM_DEF = 8;

    localparam logic [DIM_W-1:0] RESET_DIM = 4'd8;

    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic             bank;
    } t_job;

    typedef struct packed {
        logic              en;
        logic              bank;
        logic [PROD_W-1:0] idx;
        logic [DATA_W-1:0] data;
    } t_wr;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] max_v);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > max_v) begin
            res = max_v;
        end
        return res;
    endfunction

endpackage

>>> hdl/spiral_order_matrix_traversal_core.sv
// Loads one element per cycle; an R x C matrix takes R*C elements, and loading
// stalls while two completed matrices wait in the job queue. The first spiral
// result is valid after the last element is accepted; results then follow one
// per cycle while the output is not stalled, plus turn states per ring of the spiral
// and a check state to retire the matrix. Two store banks overlap load and emit.
// Synchronous active-low reset clears counters, queue and output valid;
// row and column counts reset to 8. Store contents are not cleared.
`timescale 1ns / 1ps

module spiral_order_matrix_traversal_core
    import spom_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [DIM_W-1:0]         i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_element_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_spiral_value,
    output logic                     o_last_of_run
);

    t_wr  s_wr;
    t_job s_push_job;
    t_job s_head;
    logic s_push;
    logic s_pop;
    logic s_full;
    logic s_head_valid;

    spom_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_element_value(i_element_value),
        .o_in_stall     (o_in_stall),
        .i_full         (s_full),
        .o_push         (s_push),
        .o_job          (s_push_job),
        .o_wr           (s_wr)
    );

    spom_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s_push),
        .i_job       (s_push_job),
        .i_pop       (s_pop),
        .o_full      (s_full),
        .o_head_valid(s_head_valid),
        .o_head      (s_head)
    );

    spom_back #(
        .MAX_DIM(MAX_DIM)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (s_wr),
        .i_head_valid  (s_head_valid),
        .i_head        (s_head),
        .o_pop         (s_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_spiral_value(o_spiral_value),
        .o_last_of_run (o_last_of_run)
    );

endmodule

>>> hdl/spom_front.sv
`timescale 1ns / 1ps

module spom_front
    import spom_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [DIM_W-1:0]         i_cfg_wdata,
    input  logic                     i_in_valid,
    input  logic signed [DATA_W-1:0] i_element_value,
    output logic                     o_in_stall,
    input  logic                     i_full,
    output logic                     o_push,
    output t_job                     o_job,
    output t_wr                      o_wr
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DIM_W-1:0]  r_row_count;
    logic [DIM_W-1:0]  r_col_count;
    logic [CNT_W-1:0]  r_load_cnt;
    logic              r_wbank;

    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [PROD_W-1:0] total;
    logic [CNT_W-1:0]  cnt_inc;
    logic              accept;
    logic              done;

    assign rows    = clamp_dim(r_row_count, DIM_W'(MAX_DIM));
    assign cols    = clamp_dim(r_col_count, DIM_W'(MAX_DIM));
    assign total   = PROD_W'(rows) * PROD_W'(cols);
    assign accept  = i_in_valid && !i_full;
    assign cnt_inc = r_load_cnt + CNT_W'(1);
    assign done    = PROD_W'(cnt_inc) >= total;

    assign o_in_stall = i_full;
    assign o_push     = accept && done;
    assign o_job      = '{rows: rows, cols: cols, bank: r_wbank};
    assign o_wr       = '{en: accept, bank: r_wbank, idx: PROD_W'(r_load_cnt),
                          data: i_element_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= RESET_DIM;
            r_col_count <= RESET_DIM;
            r_load_cnt  <= '0;
            r_wbank     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROW_COUNT: r_row_count <= i_cfg_wdata;
                    CFG_COL_COUNT: r_col_count <= i_cfg_wdata;
                    default:       r_row_count <= r_row_count;
                endcase
            end
            if (accept) begin
                if (done) begin
                    r_load_cnt <= '0;
                    r_wbank    <= !r_wbank;
                end else begin
                    r_load_cnt <= cnt_inc;
                end
            end
        end
    end

endmodule

>>> hdl/spom_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spom_queue
    import spom_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_head_valid,
    output t_job o_head
);

    localparam logic [1:0] FULL_COUNT = 2'd2;

    t_job       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full       = r_count == FULL_COUNT;
    assign o_head_valid = r_count != 2'd0;
    assign o_head       = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_NEVER(a_push_full, i_push && o_full, "job pushed into full queue")
    `ASSERT_NEVER(a_pop_empty, i_pop && !o_head_valid, "job popped from empty queue")

endmodule

>>> hdl/spom_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spom_back
    import spom_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_wr                      i_wr,
    input  logic                     i_head_valid,
    input  t_job                     i_head,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_spiral_value,
    output logic                     o_last_of_run
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        P_IDLE,
        P_CHECK,
        P_TOP,
        P_RIGHT,
        P_BOT,
        P_LEFT
    } t_phase;

    logic [DATA_W-1:0] r_mem [2**(ADDR_W+1)];

    t_phase                   r_phase, n_phase;
    logic signed [IDX_W-1:0]  r_t, n_t;
    logic signed [IDX_W-1:0]  r_b, n_b;
    logic signed [IDX_W-1:0]  r_l, n_l;
    logic signed [IDX_W-1:0]  r_r, n_r;
    logic signed [IDX_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_rd_pend;
    logic                     r_rd_last;
    logic [DATA_W-1:0]        r_rd_data;
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_data;
    logic                     r_out_last;

    logic signed [IDX_W-1:0]  e_row;
    logic signed [IDX_W-1:0]  e_col;
    logic                     issue;
    logic                     move;
    logic                     can_issue;
    logic                     is_last;
    logic                     pop;
    logic [PROD_W-1:0]        total;
    logic [PROD_W-1:0]        rd_idx;
    logic [ADDR_W:0]          raddr;

    assign total     = PROD_W'(i_head.rows) * PROD_W'(i_head.cols);
    assign move      = r_rd_pend && (!r_out_valid || !i_out_stall);
    assign can_issue = !r_rd_pend || move;
    assign is_last   = (PROD_W'(r_cnt) + PROD_W'(1)) == total;
    assign rd_idx    = PROD_W'(e_row[DIM_W-1:0]) * PROD_W'(i_head.cols)
                     + PROD_W'(e_col[DIM_W-1:0]);
    assign raddr     = {i_head.bank, rd_idx[ADDR_W-1:0]};

    always_comb begin
        n_phase = r_phase;
        n_t     = r_t;
        n_b     = r_b;
        n_l     = r_l;
        n_r     = r_r;
        n_i     = r_i;
        n_cnt   = r_cnt;
        e_row   = r_t;
        e_col   = r_i;
        issue   = 1'b0;
        pop     = 1'b0;
        case (r_phase)
            P_IDLE: begin
                if (i_head_valid) begin
                    n_t     = '0;
                    n_b     = IDX_W'(i_head.rows) - IDX_W'(1);
                    n_l     = '0;
                    n_r     = IDX_W'(i_head.cols) - IDX_W'(1);
                    n_cnt   = '0;
                    n_phase = P_CHECK;
                end
            end
            P_CHECK: begin
                if (r_t <= r_b && r_l <= r_r) begin
                    n_i     = r_l;
                    n_phase = P_TOP;
                end else begin
                    pop     = 1'b1;
                    n_phase = P_IDLE;
                end
            end
            P_TOP: begin
                if (r_i <= r_r) begin
                    e_row = r_t;
                    e_col = r_i;
                    if (can_issue) begin
                        issue = 1'b1;
                        n_i   = r_i + IDX_W'(1);
                    end
                end else begin
                    n_t     = r_t + IDX_W'(1);
                    n_i     = r_t + IDX_W'(1);
                    n_phase = P_RIGHT;
                end
            end
            P_RIGHT: begin
                if (r_i <= r_b) begin
                    e_row = r_i;
                    e_col = r_r;
                    if (can_issue) begin
                        issue = 1'b1;
                        n_i   = r_i + IDX_W'(1);
                    end
                end else begin
                    n_r = r_r - IDX_W'(1);
                    if (r_t <= r_b) begin
                        n_i     = r_r - IDX_W'(1);
                        n_phase = P_BOT;
                    end else if (r_l <= n_r) begin
                        n_i     = r_b;
                        n_phase = P_LEFT;
                    end else begin
                        n_phase = P_CHECK;
                    end
                end
            end
            P_BOT: begin
                if (r_i >= r_l) begin
                    e_row = r_b;
                    e_col = r_i;
                    if (can_issue) begin
                        issue = 1'b1;
                        n_i   = r_i - IDX_W'(1);
                    end
                end else begin
                    n_b = r_b - IDX_W'(1);
                    if (r_l <= r_r) begin
                        n_i     = r_b - IDX_W'(1);
                        n_phase = P_LEFT;
                    end else begin
                        n_phase = P_CHECK;
                    end
                end
            end
            P_LEFT: begin
                if (r_i >= r_t) begin
                    e_row = r_i;
                    e_col = r_l;
                    if (can_issue) begin
                        issue = 1'b1;
                        n_i   = r_i - IDX_W'(1);
                    end
                end else begin
                    n_l     = r_l + IDX_W'(1);
                    n_phase = P_CHECK;
                end
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
        if (issue) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bank, i_wr.idx[ADDR_W-1:0]}] <= i_wr.data;
        end
        if (issue) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_IDLE;
            r_t         <= '0;
            r_b         <= '0;
            r_l         <= '0;
            r_r         <= '0;
            r_i         <= '0;
            r_cnt       <= '0;
            r_rd_pend   <= 1'b0;
            r_rd_last   <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_t     <= n_t;
            r_b     <= n_b;
            r_l     <= n_l;
            r_r     <= n_r;
            r_i     <= n_i;
            r_cnt   <= n_cnt;
            if (issue) begin
                r_rd_pend <= 1'b1;
                r_rd_last <= is_last;
            end else if (move) begin
                r_rd_pend <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_out_last  <= r_rd_last;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_data <= r_rd_data;
        end
    end

    assign o_pop          = pop;
    assign o_out_valid    = r_out_valid;
    assign o_spiral_value = r_out_data;
    assign o_last_of_run  = r_out_last;

    `ASSERT_CLK(a_job_present, r_phase != P_IDLE |-> i_head_valid, "traversal without job")
    `ASSERT_CLK(a_no_overrun, issue |-> PROD_W'(r_cnt) < total, "more reads than elements")
    `ASSERT_CLK(a_pop_complete, pop |-> PROD_W'(r_cnt) == total, "job retired early")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import spom_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int STORE_DEPTH  = MAX_DIM_DEF * MAX_DIM_DEF;
    localparam int RANDOM_ITEMS = 150;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_spiral_beat;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic                     i_cfg_index = CFG_ROW_COUNT;
    logic [DIM_W-1:0]         i_cfg_wdata = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [DATA_W-1:0] i_element_value = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_spiral_value;
    logic                     o_last_of_run;

    logic [DATA_W-1:0] elements_to_send[$];
    t_spiral_beat      spiral_due[$];

    logic [DATA_W-1:0] matrix_copy[STORE_DEPTH];
    logic [6:0]        loaded_count = '0;
    logic [DIM_W-1:0]  row_setting = RESET_DIM;
    logic [DIM_W-1:0]  col_setting = RESET_DIM;

    int           mismatch_count = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    logic         send_next;
    int           stall_mode = 0;
    int           mode_left = 0;
    t_spiral_beat oldest;

    spiral_order_matrix_traversal_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_element_value (i_element_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_spiral_value  (o_spiral_value),
        .o_last_of_run   (o_last_of_run)
    );

    always #2 i_clk = ~i_clk;

    function automatic int dim_in_use(input logic [DIM_W-1:0] setting);
        if (setting == '0) begin
            return 1;
        end
        if (setting > MAX_DIM_DEF) begin
            return MAX_DIM_DEF;
        end
        return int'(setting);
    endfunction

    function automatic void load_element(input logic [DATA_W-1:0] value);
        int rows;
        int cols;
        int top;
        int bottom;
        int left_col;
        int right_col;
        int i;
        rows = dim_in_use(row_setting);
        cols = dim_in_use(col_setting);
        if (loaded_count < STORE_DEPTH) begin
            matrix_copy[loaded_count] = value;
        end
        loaded_count = loaded_count + 7'd1;
        if (int'(loaded_count) < rows * cols) begin
            return;
        end
        loaded_count = '0;
        top = 0;
        bottom = rows - 1;
        left_col = 0;
        right_col = cols - 1;
        while (top <= bottom && left_col <= right_col) begin
            for (i = left_col; i <= right_col; i++) begin
                spiral_due.push_back('{matrix_copy[top * cols + i], 1'b0});
            end
            top++;
            for (i = top; i <= bottom; i++) begin
                spiral_due.push_back('{matrix_copy[i * cols + right_col], 1'b0});
            end
            right_col--;
            if (top <= bottom) begin
                for (i = right_col; i >= left_col; i--) begin
                    spiral_due.push_back('{matrix_copy[bottom * cols + i], 1'b0});
                end
                bottom--;
            end
            if (left_col <= right_col) begin
                for (i = bottom; i >= top; i--) begin
                    spiral_due.push_back('{matrix_copy[i * cols + left_col], 1'b0});
                end
                left_col++;
            end
        end
        spiral_due[spiral_due.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [DATA_W-1:0] random_element();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return {28'hFFF_FFFF, 4'($urandom)};
            3: return 32'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] random_dim();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return DIM_W'($urandom_range(MAX_DIM_DEF + 1, 15));
            default: return DIM_W'($urandom_range(1, MAX_DIM_DEF));
        endcase
    endfunction

    // Sender: bursts of transactions separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            send_next = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                load_element(i_element_value);
                send_next = 1'b0;
            end
            if (!send_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (elements_to_send.size() > 0) begin
                    i_element_value <= elements_to_send.pop_front();
                    send_next = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            i_in_valid <= send_next;
        end
    end

    // Receiver: switch between free flow, light and heavy back-pressure.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(20, 80);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (spiral_due.size() == 0) begin
                $error("spiral_value: no transaction expected, got %0d", o_spiral_value);
                mismatch_count++;
            end else begin
                oldest = spiral_due.pop_front();
                if (o_spiral_value !== oldest.value) begin
                    $error("spiral_value: expected %0d, got %0d", oldest.value,
                           o_spiral_value);
                    mismatch_count++;
                end
                if (o_last_of_run !== oldest.last) begin
                    $error("last_of_run: expected %0b, got %0b", oldest.last,
                           o_last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic write_reg(input logic index, input logic [DIM_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_ROW_COUNT) begin
            row_setting = value;
        end else begin
            col_setting = value;
        end
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (elements_to_send.size() != 0 || i_in_valid || spiral_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_matrices(input logic [DIM_W-1:0] rows_w,
                                input logic [DIM_W-1:0] cols_w,
                                input int count, output int queued);
        write_reg(CFG_ROW_COUNT, rows_w);
        write_reg(CFG_COL_COUNT, cols_w);
        queued = count * dim_in_use(rows_w) * dim_in_use(cols_w);
        repeat (queued) elements_to_send.push_back(random_element());
        wait_idle();
    endtask

    initial begin
        int queued;
        int random_items;
        random_items = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero dimensions act as 1x1
        write_reg(CFG_ROW_COUNT, 4'd0);
        write_reg(CFG_COL_COUNT, 4'd0);
        elements_to_send.push_back(32'h8000_0000);
        elements_to_send.push_back(32'h7FFF_FFFF);
        elements_to_send.push_back(32'h0000_0000);
        elements_to_send.push_back(32'hFFFF_FFFF);
        wait_idle();

        // bounds cross in both directions
        run_matrices(4'd2, 4'd3, 1, queued);
        run_matrices(4'd3, 4'd2, 1, queued);

        // shrink the matrix while a load is half done
        write_reg(CFG_ROW_COUNT, 4'd2);
        write_reg(CFG_COL_COUNT, 4'd2);
        elements_to_send.push_back(32'h1111_1111);
        elements_to_send.push_back(32'h2222_2222);
        wait_idle();
        write_reg(CFG_COL_COUNT, 4'd1);
        elements_to_send.push_back(32'h3333_3333);
        wait_idle();

        // oversize column count clamps to the maximum
        run_matrices(4'd1, 4'd15, 1, queued);

        run_matrices(4'd8, 4'd8, 1, queued);
        random_items += queued;
        while (random_items < RANDOM_ITEMS) begin
            run_matrices(random_dim(), random_dim(), $urandom_range(1, 3), queued);
            random_items += queued;
        end

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/spom_pkg.sv
hdl/spom_front.sv
hdl/spom_queue.sv
hdl/spom_back.sv
hdl/spiral_order_matrix_traversal_core.sv
tb/testbench.sv
